FILE: sv/bbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types and constants of the blocked Bloom filter insert block.
// ----------------------------------------------------------------------------
package bbf_pkg;

    localparam int BLOCK_INDEX_BITS = 10;
    localparam int MAX_PROBES       = 16;

    localparam int BLK_LOG2   = 9;
    localparam int BLOCK_W    = 1 << BLK_LOG2;
    localparam int POS_W      = BLK_LOG2;
    localparam int STRIDE_LOW = 5;
    localparam int HASH_W     = 64;
    localparam int HASH_LO_W  = 2 * BLK_LOG2 + BLOCK_INDEX_BITS;
    localparam int FSL_W      = 5;
    localparam int PROBE_W    = 5;
    localparam int HITS_W     = 5;
    localparam int CNT_W      = $clog2(MAX_PROBES + 1);
    localparam int DEPTH      = 1 << BLOCK_INDEX_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT      = 2'd1;

    localparam logic [FSL_W-1:0]   FSL_RESET   = 5'd19;
    localparam logic [PROBE_W-1:0] PROBE_RESET = 5'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PROBE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd;
        logic probe;
        logic done;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic zero_probes;
        logic probe_last;
        logic out_busy;
    } t_ctrl_sts;

endpackage
`default_nettype wire

FILE: sv/bbf_hash_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_hash_if
// Hash input channel: valid, ready and one 64-bit hash per transfer.
// ----------------------------------------------------------------------------
interface bbf_hash_if;
    import bbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);

endinterface
`default_nettype wire

FILE: sv/bbf_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_result_if
// Result channel: valid, ready, hit count and all-present flag per transfer.
// ----------------------------------------------------------------------------
interface bbf_result_if;
    import bbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [HITS_W-1:0] hits_already_set;
    logic              all_present;

    modport source (output valid, output hits_already_set, output all_present, input ready);
    modport sink   (input valid, input hits_already_set, input all_present, output ready);

endinterface
`default_nettype wire

FILE: sv/bbf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_ctrl
// Sequencer: clearing pass, accept, block read, probe steps, result hand-off.
// ----------------------------------------------------------------------------
module bbf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  bbf_pkg::t_ctrl_sts     i_sts,
    output bbf_pkg::t_ctrl_cmd     o_cmd
);
    import bbf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = i_sts.zero_probes ? ST_DONE : ST_PROBE;
            end
            ST_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_sts.probe_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.done = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/bbf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_datapath
// Configuration, hash decode, block store, probe row register and result.
// ----------------------------------------------------------------------------
module bbf_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bbf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bbf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [bbf_pkg::HASH_W-1:0]        i_hash_value,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [bbf_pkg::HITS_W-1:0]             o_hits_already_set,
    output logic                                   o_all_present,
    input  bbf_pkg::t_ctrl_cmd                     i_cmd,
    output bbf_pkg::t_ctrl_sts                     o_sts
);
    import bbf_pkg::*;

    localparam logic [FSL_W-1:0]   FSL_MIN   = FSL_W'(BLK_LOG2);
    localparam logic [FSL_W-1:0]   FSL_MAX   = FSL_W'(BLK_LOG2 + BLOCK_INDEX_BITS);
    localparam logic [PROBE_W-1:0] PROBE_MAX = PROBE_W'(MAX_PROBES);

    logic [FSL_W-1:0]            r_fsl;
    logic [PROBE_W-1:0]          r_probes;
    logic [BLOCK_INDEX_BITS-1:0] r_clr_addr;
    logic [BLOCK_INDEX_BITS-1:0] r_block;
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            r_stride;
    logic [CNT_W-1:0]            r_nprobe;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            r_hits;
    logic [BLOCK_W-1:0]          r_row;
    logic                        r_out_valid;
    logic [HITS_W-1:0]           r_out_hits;
    logic                        r_out_all;
    logic [BLOCK_W-1:0]          r_mem [DEPTH];

    logic [FSL_W-1:0]            fsl_eff;
    logic [FSL_W-1:0]            xbits;
    logic [PROBE_W-1:0]          probes_eff;
    logic [HASH_LO_W-1:0]        hash_lo;
    logic [BLOCK_INDEX_BITS-1:0] blk_mask;
    logic [BLOCK_INDEX_BITS-1:0] blk;
    logic [POS_W-1:0]            start;
    logic [POS_W-1:0]            stride_raw;
    logic [POS_W-1:0]            stride;
    logic                        hit;
    logic [BLOCK_W-1:0]          row_set;

    always_comb begin
        priority if (r_fsl < FSL_MIN) begin
            fsl_eff = FSL_MIN;
        end else if (r_fsl > FSL_MAX) begin
            fsl_eff = FSL_MAX;
        end else begin
            fsl_eff = r_fsl;
        end
        probes_eff = (r_probes > PROBE_MAX) ? PROBE_MAX : r_probes;
        xbits      = fsl_eff - FSL_MIN;
        hash_lo    = i_hash_value[HASH_LO_W-1:0];
        blk_mask   = ~({BLOCK_INDEX_BITS{1'b1}} << xbits);
        blk        = i_hash_value[BLOCK_INDEX_BITS-1:0] & blk_mask;
        start      = POS_W'(hash_lo >> xbits);
        stride_raw = POS_W'(hash_lo >> fsl_eff);
        stride     = (stride_raw[STRIDE_LOW-1:0] == '0) ? POS_W'(stride_raw + 1'b1)
                                                        : stride_raw;
        hit        = r_row[r_pos];
        row_set    = r_row | (BLOCK_W'(1) << r_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsl       <= FSL_RESET;
            r_probes    <= PROBE_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FILTER_SIZE_LOG2) begin
                    r_fsl <= FSL_W'(i_cfg_data);
                end else if (i_cfg_index == CFG_PROBE_COUNT) begin
                    r_probes <= PROBE_W'(i_cfg_data);
                end
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_block  <= blk;
            r_pos    <= start;
            r_stride <= stride;
            r_nprobe <= CNT_W'(probes_eff);
            r_cnt    <= '0;
            r_hits   <= '0;
        end else if (i_cmd.probe) begin
            r_pos  <= r_pos + r_stride;
            r_cnt  <= r_cnt + 1'b1;
            r_hits <= r_hits + CNT_W'(hit);
        end
        if (i_cmd.done) begin
            r_out_hits <= HITS_W'(r_hits);
            r_out_all  <= (r_hits == r_nprobe);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.probe && o_sts.probe_last) begin
            r_mem[r_block] <= row_set;
        end
        if (i_cmd.rd) begin
            r_row <= r_mem[r_block];
        end else if (i_cmd.probe) begin
            r_row <= row_set;
        end
    end

    always_comb begin
        o_sts.clr_last    = (r_clr_addr == {BLOCK_INDEX_BITS{1'b1}});
        o_sts.zero_probes = (r_nprobe == '0);
        o_sts.probe_last  = (r_cnt == CNT_W'(r_nprobe - 1'b1));
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid        = r_out_valid;
    assign o_hits_already_set = r_out_hits;
    assign o_all_present      = r_out_all;

endmodule
`default_nettype wire

FILE: sv/blocked_bloom_filter_insert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blocked_bloom_filter_insert
// Blocked Bloom filter insert over 512-bit blocks: probe, count and set bits.
// Each insert makes n probes, n = probe count after the limit of 16 is applied.
// A new hash is taken only once the previous insert has handed its result to
// the output register; the probe loop runs one bit per cycle on a 512-bit row
// register read from and written back to the store.
// Reset: a clearing pass over all 1024 rows, one row per cycle, zeroes
// the store; no hash is taken during it, configuration writes are.
// ----------------------------------------------------------------------------
module blocked_bloom_filter_insert (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bbf_hash_if.sink                            i_hash,
    bbf_result_if.source                        o_result
);
    import bbf_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    bbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_hash.valid),
        .o_in_ready (i_hash.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bbf_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_hash_value       (i_hash.hash_value),
        .i_out_ready        (o_result.ready),
        .o_out_valid        (o_result.valid),
        .o_hits_already_set (o_result.hits_already_set),
        .o_all_present      (o_result.all_present),
        .i_cmd              (cmd),
        .o_sts              (sts)
    );

endmodule
`default_nettype wire
